// ===== hdl/mcwt_pkg.sv =====
// package for the multi-client watchdog table
// holds the payload words, opcode, status and config index codes
// no dependencies
package mcwt_pkg;

    // fixed field widths of the payload words
    localparam int OPCODE_W  = 3;
    localparam int CLIENT_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_REG   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UNREG = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FEED  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CHECK = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 4'd1;

    // reset value of the check period
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

    // input word
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CLIENT_W-1:0] client_id;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                starve_valid;
        logic [CLIENT_W-1:0] starved_id;
        logic                last;
    } t_out_word;

    // build one result word
    function automatic t_out_word mk_out(input logic [STATUS_W-1:0] status,
                                         input logic                sv,
                                         input logic [CLIENT_W-1:0] id,
                                         input logic                last);
        t_out_word w;
        w.status       = status;
        w.starve_valid = sv;
        w.starved_id   = id;
        w.last         = last;
        return w;
    endfunction

endpackage

// ===== hdl/mcwt_slot_mem.sv =====
// slot table storage: client id and pending flag per slot
// one synchronous read port, one write port, per-slot valid bits
// depends on mcwt_pkg
module mcwt_slot_mem
    import mcwt_pkg::*;
#(
    parameter int MAX_CLIENTS = 16,
    parameter int ID_BITS     = 16,
    parameter int AW          = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [ID_BITS-1:0] i_wr_id,
    input  logic               i_wr_flag,
    output logic [ID_BITS-1:0] o_rd_id,
    output logic               o_rd_flag
);

    localparam int DW = ID_BITS + 1;

    logic [DW-1:0]          r_mem [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] r_vld;
    logic [DW-1:0]          r_rd_word;
    logic                   r_rd_vld;

    // storage array, flag in the top bit
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_flag, i_wr_id};
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // written marks, a slot never written reads as empty with a clear flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // read data, masked by the written mark
    assign o_rd_id   = r_rd_vld ? r_rd_word[ID_BITS-1:0] : '0;
    assign o_rd_flag = r_rd_vld & r_rd_word[DW-1];

endmodule

// ===== hdl/mcwt_seq.sv =====
// sequencer of the watchdog table: decodes a word, scans the slot table
// one slot per cycle, writes back and forms the result words
// depends on mcwt_pkg, drives mcwt_slot_mem
module mcwt_seq
    import mcwt_pkg::*;
#(
    parameter int MAX_CLIENTS = 16,
    parameter int ID_BITS     = 16,
    parameter int AW          = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_in_word            i_in,
    output logic                o_busy,
    output logic                o_strobe,
    output t_out_word           o_res,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_check_en,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [ID_BITS-1:0]  o_wr_id,
    output logic                o_wr_flag,
    input  logic [ID_BITS-1:0]  i_rd_id,
    input  logic                i_rd_flag
);

    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CLIENTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_CLIENTS);

    // state codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_count, n_count;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_hold_vld, n_hold_vld;
    logic [ID_BITS-1:0]  r_hold_id, n_hold_id;
    logic                r_strobe, n_strobe;
    t_out_word           r_out, n_out;

    logic [ID_BITS-1:0]  w_in_id;
    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W-1:0] w_tick_inc;
    logic                w_last_addr;
    logic                w_match;

    // id width conversions between the port fields and the table
    function automatic logic [CLIENT_W-1:0] out_id(input logic [ID_BITS-1:0] id);
        logic [31:0] ext;
        ext = 32'(id);
        return ext[CLIENT_W-1:0];
    endfunction

    always_comb begin
        logic [31:0] ext;
        ext     = 32'(i_in.client_id);
        w_in_id = ext[ID_BITS-1:0];
    end

    // period of zero behaves as one
    assign w_period    = (i_period == '0) ? PERIOD_W'(1) : i_period;
    assign w_tick_inc  = r_tick + PERIOD_W'(1);
    assign w_last_addr = (r_addr == LAST_ADDR);
    assign w_match     = (r_op == OP_REG) ? (i_rd_id == '0) : (i_rd_id == r_id);

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_addr     = r_addr;
        n_count    = r_count;
        n_tick     = r_tick;
        n_hold_vld = r_hold_vld;
        n_hold_id  = r_hold_id;
        n_strobe   = 1'b0;
        n_out      = r_out;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_addr + AW'(1);
        o_wr_en    = 1'b0;
        o_wr_addr  = r_addr;
        o_wr_id    = i_rd_id;
        o_wr_flag  = i_rd_flag;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_in.opcode;
                    n_id = w_in_id;
                    if (i_in.opcode <= OP_CHECK && w_in_id == '0) begin
                        n_strobe = 1'b1;
                        n_out    = mk_out(ST_INVALID, 1'b0, '0, 1'b1);
                    end else begin
                        case (i_in.opcode) inside
                            OP_REG: begin
                                if (r_count >= FULL_CNT) begin
                                    n_strobe = 1'b1;
                                    n_out    = mk_out(ST_FULL, 1'b0, '0, 1'b1);
                                end else begin
                                    o_rd_en   = 1'b1;
                                    o_rd_addr = '0;
                                    n_addr    = '0;
                                    n_state   = S_SCAN;
                                end
                            end
                            OP_UNREG, OP_FEED, OP_CHECK: begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_addr    = '0;
                                n_state   = S_SCAN;
                            end
                            OP_TICK: begin
                                if (!i_check_en) begin
                                    n_strobe = 1'b1;
                                    n_out    = mk_out(ST_OK, 1'b0, '0, 1'b1);
                                end else if (w_tick_inc < w_period && w_tick_inc != '0) begin
                                    n_tick   = w_tick_inc;
                                    n_strobe = 1'b1;
                                    n_out    = mk_out(ST_OK, 1'b0, '0, 1'b1);
                                end else begin
                                    n_tick     = '0;
                                    n_hold_vld = 1'b0;
                                    o_rd_en    = 1'b1;
                                    o_rd_addr  = '0;
                                    n_addr     = '0;
                                    n_state    = S_SWEEP;
                                end
                            end
                            default: begin
                                n_strobe = 1'b1;
                                n_out    = mk_out(ST_OK, 1'b0, '0, 1'b1);
                            end
                        endcase
                    end
                end
            end

            // look for the matching slot, or the first empty one
            S_SCAN: begin
                if (!w_last_addr) begin
                    o_rd_en = 1'b1;
                    n_addr  = r_addr + AW'(1);
                end
                if (w_match) begin
                    o_wr_en  = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    n_out    = mk_out(ST_OK, 1'b0, '0, 1'b1);
                    case (r_op)
                        OP_REG: begin
                            o_wr_id   = r_id;
                            o_wr_flag = 1'b0;
                            n_count   = r_count + CW'(1);
                        end
                        OP_UNREG: begin
                            o_wr_id = '0;
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_FEED: begin
                            o_wr_flag = 1'b0;
                        end
                        default: begin
                            // check one: report if already pending, then set
                            o_wr_flag = 1'b1;
                            if (i_rd_flag) begin
                                n_out = mk_out(ST_OK, 1'b1, out_id(r_id), 1'b1);
                            end
                        end
                    endcase
                end else if (w_last_addr) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    n_out    = mk_out((r_op == OP_REG) ? ST_FULL : ST_NOT_FOUND,
                                      1'b0, '0, 1'b1);
                end
            end

            // whole-table check, one result held back to mark the last one
            S_SWEEP: begin
                o_wr_en   = 1'b1;
                o_wr_flag = 1'b1;
                if (i_rd_id != '0 && i_rd_flag) begin
                    if (r_hold_vld) begin
                        n_strobe = 1'b1;
                        n_out    = mk_out(ST_OK, 1'b1, out_id(r_hold_id), 1'b0);
                    end
                    n_hold_vld = 1'b1;
                    n_hold_id  = i_rd_id;
                end
                if (w_last_addr) begin
                    n_state = S_FLUSH;
                end else begin
                    o_rd_en = 1'b1;
                    n_addr  = r_addr + AW'(1);
                end
            end

            // final word of a sweep
            S_FLUSH: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_hold_vld) begin
                    n_out = mk_out(ST_OK, 1'b1, out_id(r_hold_id), 1'b1);
                end else begin
                    n_out = mk_out(ST_OK, 1'b0, '0, 1'b1);
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_tick     <= '0;
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_tick     <= n_tick;
            r_hold_vld <= n_hold_vld;
            r_strobe   <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_addr    <= n_addr;
        r_hold_id <= n_hold_id;
        r_out     <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_out;

`ifndef NO_ASSERTIONS
    // an accepted word is either still in work or answered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_strobe))
        else $error("accepted word neither in work nor answered");

    // the final word of an item leaves the sequencer idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |-> !o_busy)
        else $error("final word while still busy");

    // a word that is not final comes only from a sweep in progress
    a_mid_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |-> (r_state == S_SWEEP || r_state == S_FLUSH))
        else $error("non-final word outside a sweep");

    // a starve report carries a nonzero id and ok status
    a_starve_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.starve_valid) |-> (o_res.starved_id != '0 && o_res.status == ST_OK))
        else $error("starve word with empty id or bad status");

    // client count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("client count above table size");
`endif

endmodule

// ===== hdl/multi_client_watchdog_table.sv =====
// top level of the multi-client watchdog table
// holds the configuration registers, instantiates mcwt_seq and mcwt_slot_mem
// depends on mcwt_pkg
//
// usage:
//   input words (opcode, client id) are taken when i_start is high and o_busy
//   is low. results come out on o_res, each valid for one cycle with o_strobe
//   high; the receiver cannot hold them off. the word with o_res.last set ends
//   the item, and o_busy is low in that same cycle, so the next word can be
//   taken then.
//   answers: a zero id with any opcode but tick, a full table, an unused
//   opcode and a tick that does not end a period answer in the cycle after
//   acceptance. register, unregister, feed and check walk the slot memory
//   one slot per cycle from slot 0 and answer once a slot matches or the
//   last slot is read. a tick that ends a period sweeps every slot and gives
//   its last word after the last slot is read. the single read port of the
//   slot memory sets this pace; one item is in work at a time.
//   configuration: i_cfg_we writes register i_cfg_idx (0 check period, 1
//   checking enable) at once; write only while o_busy is low.
//   reset (synchronous, active low) empties the table, clears the client
//   count and tick counter, and sets period 100 with checking suspended.
module multi_client_watchdog_table
    import mcwt_pkg::*;
#(
    parameter int MAX_CLIENTS = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_word             i_in,
    output logic                 o_busy,
    output logic                 o_strobe,
    output t_out_word            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

    logic [PERIOD_W-1:0] r_period;
    logic                r_check_en;

    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [ID_BITS-1:0] w_wr_id;
    logic               w_wr_flag;
    logic [ID_BITS-1:0] w_rd_id;
    logic               w_rd_flag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RST;
            r_check_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD: r_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_ENABLE: r_check_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    mcwt_seq #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .ID_BITS     (ID_BITS),
        .AW          (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_in       (i_in),
        .o_busy     (o_busy),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_period   (r_period),
        .i_check_en (r_check_en),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_id    (w_wr_id),
        .o_wr_flag  (w_wr_flag),
        .i_rd_id    (w_rd_id),
        .i_rd_flag  (w_rd_flag)
    );

    // slot table
    mcwt_slot_mem #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .ID_BITS     (ID_BITS),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_id   (w_wr_id),
        .i_wr_flag (w_wr_flag),
        .o_rd_id   (w_rd_id),
        .o_rd_flag (w_rd_flag)
    );

endmodule
